// ----- hdl/mrc_pkg.sv -----
// shared types and constants for the memory range coalescer
`default_nettype none

package mrc_pkg;

  // memory type codes that take part in merging
  localparam logic [31:0] TYPE_BOOT_CODE    = 32'd3;
  localparam logic [31:0] TYPE_BOOT_DATA    = 32'd4;
  localparam logic [31:0] TYPE_CONVENTIONAL = 32'd7;

  // log2 of the page size in bytes
  localparam int unsigned PAGE_SHIFT = 12;

  // result queue depth and pointer widths
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // incoming descriptor request
  typedef struct packed {
    logic [31:0] range_type;
    logic [63:0] phys_base;
    logic [63:0] virt_base;
    logic [63:0] page_total;
    logic [63:0] attr_bits;
    logic        last_in;
  } desc_in_t;

  // emitted descriptor request
  typedef struct packed {
    logic [31:0] out_type;
    logic [63:0] out_phys;
    logic [63:0] out_virt;
    logic [63:0] out_pages;
    logic [63:0] out_attr;
    logic        out_last;
  } desc_out_t;

  // results produced by one descriptor, first then second
  typedef struct packed {
    logic [1:0] count;
    desc_out_t  first;
    desc_out_t  second;
  } push_t;

  // queue status seen by the merge stage
  typedef struct packed {
    logic              room;
    logic [QCNT_W-1:0] level;
  } qstat_t;

  // types that may be coalesced
  function automatic logic mergeable(input logic [31:0] t);
    mergeable = (t == TYPE_BOOT_CODE) || (t == TYPE_BOOT_DATA) ||
                (t == TYPE_CONVENTIONAL);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/memory_range_coalescer.sv -----
// top level of the memory range coalescer
`default_nettype none

// Merges a stream of memory map descriptors: adjacent boot code, boot data
// and conventional ranges with equal attributes are joined into one
// conventional range, and the final descriptor of a map flushes the pending
// one with out_last set. A descriptor is taken every cycle unless the input
// stalls; it is merged while it sits in the input register, and its results
// are written into the result queue and offered at the output from there.
// A descriptor may yield two results (a replaced range and the final flush)
// while the output side delivers one per cycle when not stalled, so a
// four-entry result queue absorbs the extra one; input stalls only when
// fewer than two queue slots are free with a descriptor waiting.
module memory_range_coalescer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               desc_valid,
  output logic                    desc_stall,
  input  wire mrc_pkg::desc_in_t  desc,
  output logic                    merged_valid,
  input  wire logic               merged_stall,
  output mrc_pkg::desc_out_t      merged
);

  mrc_pkg::push_t  push;
  mrc_pkg::qstat_t qstat;

  // merge stage
  mrc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc),
    .qstat      (qstat),
    .push       (push)
  );

  // result queue
  mrc_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .qstat        (qstat),
    .merged_valid (merged_valid),
    .merged_stall (merged_stall),
    .merged       (merged)
  );

  // results are only pushed when two slots were free
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> qstat.room)
    else $error("result pushed without queue room");

  // a pair of results is always a replaced range then the final flush
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.second.out_last && !push.first.out_last))
    else $error("bad ordering of paired results");

  // pushed results raise the queue level on the next cycle
  a_level_up: assert property (@(posedge clk) disable iff (rst)
    ((push.count != 2'd0) && !merged_valid) |=> (qstat.level != '0))
    else $error("queue level did not follow a push");

endmodule

`default_nettype wire

// ----- hdl/mrc_core.sv -----
// input register, pending descriptor and merge decision
`default_nettype none

module mrc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            desc_valid,
  output logic                 desc_stall,
  input  wire mrc_pkg::desc_in_t desc,
  input  wire mrc_pkg::qstat_t qstat,
  output mrc_pkg::push_t       push
);

  logic               stg_valid;
  mrc_pkg::desc_in_t  stg;
  logic               held_valid;
  logic [31:0]        held_type;
  logic [63:0]        held_phys;
  logic [63:0]        held_virt;
  logic [63:0]        held_pages;
  logic [63:0]        held_attr;

  logic               held_valid_next;
  logic [31:0]        held_type_next;
  logic [63:0]        held_phys_next;
  logic [63:0]        held_virt_next;
  logic [63:0]        held_pages_next;
  logic [63:0]        held_attr_next;

  logic               proc;
  logic               take;
  logic [63:0]        top;
  logic               merge;
  logic               emit_old;
  mrc_pkg::desc_out_t old_range;
  mrc_pkg::desc_out_t new_range;

  // the waiting request is resolved once the queue can take two results
  assign proc       = stg_valid && qstat.room;
  assign desc_stall = stg_valid && !qstat.room;
  assign take       = desc_valid && !desc_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg       <= '0;
    end else begin
      if (take) begin
        stg_valid <= 1'b1;
        stg       <= desc;
      end else if (proc) begin
        stg_valid <= 1'b0;
      end
    end
  end

  // merge test, new pending descriptor and results
  always_comb begin
    top      = held_phys + (held_pages << mrc_pkg::PAGE_SHIFT);
    merge    = held_valid && (held_attr == stg.attr_bits) && (top == stg.phys_base) &&
               mrc_pkg::mergeable(stg.range_type) && mrc_pkg::mergeable(held_type);
    emit_old = held_valid && !merge;

    if (merge) begin
      held_type_next  = mrc_pkg::TYPE_CONVENTIONAL;
      held_phys_next  = held_phys;
      held_virt_next  = held_virt;
      held_pages_next = held_pages + stg.page_total;
      held_attr_next  = held_attr;
    end else begin
      held_type_next  = stg.range_type;
      held_phys_next  = stg.phys_base;
      held_virt_next  = stg.virt_base;
      held_pages_next = stg.page_total;
      held_attr_next  = stg.attr_bits;
    end
    held_valid_next = !stg.last_in;

    // replaced range, never final
    old_range.out_type  = held_type;
    old_range.out_phys  = held_phys;
    old_range.out_virt  = held_virt;
    old_range.out_pages = held_pages;
    old_range.out_attr  = held_attr;
    old_range.out_last  = 1'b0;

    // pending range as flushed by the final request
    new_range.out_type  = held_type_next;
    new_range.out_phys  = held_phys_next;
    new_range.out_virt  = held_virt_next;
    new_range.out_pages = held_pages_next;
    new_range.out_attr  = held_attr_next;
    new_range.out_last  = 1'b1;

    push.count  = 2'd0;
    push.first  = old_range;
    push.second = new_range;
    if (proc) begin
      push.count = {1'b0, emit_old} + {1'b0, stg.last_in};
      if (!emit_old) begin
        push.first = new_range;
      end
    end
  end

  // pending descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_type  <= '0;
      held_phys  <= '0;
      held_virt  <= '0;
      held_pages <= '0;
      held_attr  <= '0;
    end else if (proc) begin
      held_valid <= held_valid_next;
      held_type  <= held_type_next;
      held_phys  <= held_phys_next;
      held_virt  <= held_virt_next;
      held_pages <= held_pages_next;
      held_attr  <= held_attr_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mrc_outq.sv -----
// four-entry result queue taking up to two results per cycle
`default_nettype none

module mrc_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mrc_pkg::push_t   push,
  output mrc_pkg::qstat_t       qstat,
  output logic                  merged_valid,
  input  wire logic             merged_stall,
  output mrc_pkg::desc_out_t    merged
);

  mrc_pkg::desc_out_t              mem [mrc_pkg::QUEUE_DEPTH];
  logic [mrc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mrc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mrc_pkg::QCNT_W-1:0]      cnt;
  logic [mrc_pkg::QCNT_W-1:0]      cnt_next;
  logic [mrc_pkg::QPTR_W-1:0]      wr_ptr_next;
  logic                            pop;

  // pop when the head is taken downstream
  assign pop          = (cnt != '0) && !merged_stall;
  assign merged_valid = (cnt != '0);
  assign merged       = mem[rd_ptr];

  // room for two more results, judged on the registered level
  assign qstat.room  = (cnt <= mrc_pkg::QCNT_W'(mrc_pkg::QUEUE_DEPTH - 2));
  assign qstat.level = cnt;

  always_comb begin
    cnt_next    = cnt + mrc_pkg::QCNT_W'(push.count) - mrc_pkg::QCNT_W'(pop);
    wr_ptr_next = wr_ptr + mrc_pkg::QPTR_W'(push.count);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      cnt    <= cnt_next;
      if (pop) begin
        rd_ptr <= rd_ptr + mrc_pkg::QPTR_W'(1);
      end
    end
  end

  // storage, up to two writes at consecutive slots
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + mrc_pkg::QPTR_W'(1)] <= push.second;
    end
  end

endmodule

`default_nettype wire
